// ----- rtl/ste_pkg.sv -----
// Shared types and constants for the session table with aging.
// No dependencies; used by ste_front, ste_back and session_table_with_aging.
package ste_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned IdW      = 32;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned LiveW    = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Command codes carried in the item.
  typedef enum logic [CmdW-1:0] {
    CMD_REG   = 3'd0,
    CMD_UNREG = 3'd1,
    CMD_HBEAT = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_FIND  = 3'd4,
    CMD_FILT  = 3'd5,
    CMD_RSVD  = 3'd6,
    CMD_BAD   = 3'd7
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HB_RELOAD = 3'd0,
    CFG_QUOTE_ONE = 3'd1,
    CFG_QUOTE_TWO = 3'd2,
    CFG_ORDER_ONE = 3'd3,
    CFG_ORDER_TWO = 3'd4
  } cfg_idx_e;

  localparam logic [TimeW-1:0] HbReloadRst = 16'd30;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdW-1:0]   session_id;
    logic [TimeW-1:0] initial_time;
    logic             quote_enabled;
    logic             order_enabled;
    logic [IdW-1:0]   msg_type;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic             expired;
    logic [IdW-1:0]   expired_id;
    logic [LiveW-1:0] live_count;
    logic             last;
  } out_item_t;

  // Queue head handed from front to back.
  typedef struct packed {
    logic     vld;
    cmd_e     cls;
    in_item_t item;
  } head_t;

endpackage

// ----- rtl/ste_front.sv -----
// Front end: accepts items into a two-entry queue and classifies the command.
// Depends on ste_pkg.
module ste_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ste_pkg::in_item_t in_item_i,
  output ste_pkg::head_t    head_o,
  input  logic              pop_i
);

  ste_pkg::in_item_t fifo_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        fill_q, fill_d;
  logic              push, pop;
  ste_pkg::in_item_t head_item;

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (fill_q != 2'd0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item_i;
    end
  end

  assign head_item = fifo_q[rd_ptr_q];

  // Classify the command at the queue head
  always_comb begin
    head_o.vld  = (fill_q != 2'd0);
    head_o.item = head_item;
    unique case (head_item.cmd)
      ste_pkg::CMD_REG:   head_o.cls = ste_pkg::CMD_REG;
      ste_pkg::CMD_UNREG: head_o.cls = ste_pkg::CMD_UNREG;
      ste_pkg::CMD_HBEAT: head_o.cls = ste_pkg::CMD_HBEAT;
      ste_pkg::CMD_TICK:  head_o.cls = ste_pkg::CMD_TICK;
      ste_pkg::CMD_FIND:  head_o.cls = ste_pkg::CMD_FIND;
      ste_pkg::CMD_FILT:  head_o.cls = ste_pkg::CMD_FILT;
      default:            head_o.cls = ste_pkg::CMD_BAD;
    endcase
  end

endmodule

// ----- rtl/ste_back.sv -----
// Back end: session table, command execution, expiry scan and output register.
// Depends on ste_pkg; fed by ste_front.
module ste_back #(
  parameter int unsigned Depth = ste_pkg::DepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ste_pkg::head_t                  head_i,
  output logic                            pop_o,
  input  logic                            cfg_we_i,
  input  logic [ste_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ste_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ste_pkg::out_item_t              out_item_o
);

  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [IW-1:0] LastIdx = IW'(Depth - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_TICK = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Table storage
  logic [Depth-1:0]               valid_q, valid_d;
  logic [Depth-1:0]               gone_q, gone_d;
  logic [ste_pkg::IdW-1:0]        key_q   [Depth];
  logic [ste_pkg::TimeW-1:0]      cnt_q   [Depth];
  logic [Depth-1:0]               qok_q, ook_q;
  logic [CW-1:0]                  live_q, live_d;

  // Configuration
  logic [ste_pkg::TimeW-1:0]      hb_reload_q;
  logic [ste_pkg::IdW-1:0]        quote_one_q, quote_two_q, order_one_q, order_two_q;

  // Latched command
  ste_pkg::cmd_e                  cls_q;
  ste_pkg::in_item_t              item_q;
  logic                           hit_q, free_q;
  logic [IW-1:0]                  slot_q, free_idx_q;

  // Scan state
  logic [IW-1:0]                  idx_q, idx_d;
  logic                           found_q, found_d;
  logic [ste_pkg::IdW-1:0]        min_key_q, min_key_d;
  logic [IW-1:0]                  min_idx_q, min_idx_d;
  logic                           first_q, first_d;

  // Output register
  logic                           out_vld_q, out_vld_d;
  ste_pkg::out_item_t             out_q, out_d;

  logic                           can_emit;
  logic                           hit_c, free_c;
  logic [IW-1:0]                  slot_c, free_idx_c;
  logic                           blocked;
  logic [31:0]                    live_ext;
  logic [ste_pkg::LiveW-1:0]      live_sat;

  // Table write controls
  logic                           wr_new;
  logic                           wr_hb;
  logic                           do_tick;

  assign can_emit    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Parallel compare against the queue head
  always_comb begin
    hit_c      = 1'b0;
    slot_c     = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == head_i.item.session_id) begin
        hit_c  = 1'b1;
        slot_c = IW'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  // Filter decision for the matched slot
  always_comb begin
    blocked = 1'b0;
    if (!qok_q[slot_q] &&
        (item_q.msg_type == quote_one_q || item_q.msg_type == quote_two_q)) begin
      blocked = 1'b1;
    end else if (!ook_q[slot_q] &&
        (item_q.msg_type == order_one_q || item_q.msg_type == order_two_q)) begin
      blocked = 1'b1;
    end
  end

  // Saturate the live count to the result width
  always_comb begin
    live_ext = 32'(live_d);
    live_sat = (live_ext > 32'd31) ? 5'd31 : live_ext[ste_pkg::LiveW-1:0];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    gone_d    = gone_q;
    live_d    = live_q;
    idx_d     = idx_q;
    found_d   = found_q;
    min_key_d = min_key_q;
    min_idx_d = min_idx_q;
    first_d   = first_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    pop_o     = 1'b0;
    wr_new    = 1'b0;
    wr_hb     = 1'b0;
    do_tick   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.vld) begin
          pop_o   = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cls_q == ste_pkg::CMD_TICK) begin
          state_d = ST_TICK;
        end else if (can_emit) begin
          out_d.ok         = 1'b0;
          out_d.expired    = 1'b0;
          out_d.expired_id = '0;
          out_d.last       = 1'b1;
          case (cls_q)
            ste_pkg::CMD_REG: begin
              if (!hit_q && free_q) begin
                wr_new             = 1'b1;
                valid_d[free_idx_q] = 1'b1;
                live_d             = live_q + CW'(1);
                out_d.ok           = 1'b1;
              end
            end
            ste_pkg::CMD_UNREG: begin
              if (hit_q) begin
                valid_d[slot_q] = 1'b0;
                live_d          = live_q - CW'(1);
                out_d.ok        = 1'b1;
              end
            end
            ste_pkg::CMD_HBEAT: begin
              wr_hb    = hit_q;
              out_d.ok = hit_q;
            end
            ste_pkg::CMD_FIND: out_d.ok = hit_q;
            ste_pkg::CMD_FILT: out_d.ok = hit_q && blocked;
            default:           out_d.ok = 1'b0;
          endcase
          out_d.live_count = live_sat;
          out_vld_d        = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_TICK: begin
        // Mark entries at zero, drop them, decrement the rest
        do_tick = 1'b1;
        for (int i = 0; i < Depth; i++) begin
          if (valid_q[i] && cnt_q[i] == '0) begin
            gone_d[i]  = 1'b1;
            valid_d[i] = 1'b0;
          end
        end
        idx_d   = '0;
        found_d = 1'b0;
        first_d = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // Track the smallest removed key; first pass also settles live count
        if (gone_q[idx_q]) begin
          if (first_q) begin
            live_d = live_q - CW'(1);
          end
          if (!found_q || key_q[idx_q] < min_key_q) begin
            found_d   = 1'b1;
            min_key_d = key_q[idx_q];
            min_idx_d = idx_q;
          end
        end
        if (idx_q == LastIdx) begin
          state_d = ST_EMIT;
          first_d = 1'b0;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_d.ok         = 1'b1;
          out_d.live_count = live_sat;
          out_vld_d        = 1'b1;
          if (found_q) begin
            out_d.expired     = 1'b1;
            out_d.expired_id  = min_key_q;
            out_d.last        = 1'b0;
            gone_d[min_idx_q] = 1'b0;
            found_d           = 1'b0;
            idx_d             = '0;
            state_d           = ST_SCAN;
          end else begin
            out_d.expired    = 1'b0;
            out_d.expired_id = '0;
            out_d.last       = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      gone_q      <= '0;
      live_q      <= '0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      hb_reload_q <= ste_pkg::HbReloadRst;
      quote_one_q <= '0;
      quote_two_q <= '0;
      order_one_q <= '0;
      order_two_q <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      gone_q    <= gone_d;
      live_q    <= live_d;
      found_q   <= found_d;
      first_q   <= first_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ste_pkg::CFG_HB_RELOAD: hb_reload_q <= cfg_wdata_i[ste_pkg::TimeW-1:0];
          ste_pkg::CFG_QUOTE_ONE: quote_one_q <= cfg_wdata_i;
          ste_pkg::CFG_QUOTE_TWO: quote_two_q <= cfg_wdata_i;
          ste_pkg::CFG_ORDER_ONE: order_one_q <= cfg_wdata_i;
          ste_pkg::CFG_ORDER_TWO: order_two_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    idx_q     <= idx_d;
    min_key_q <= min_key_d;
    min_idx_q <= min_idx_d;
    if (pop_o) begin
      cls_q      <= head_i.cls;
      item_q     <= head_i.item;
      hit_q      <= hit_c;
      slot_q     <= slot_c;
      free_q     <= free_c;
      free_idx_q <= free_idx_c;
    end
    if (wr_new) begin
      key_q[free_idx_q] <= item_q.session_id;
      cnt_q[free_idx_q] <= item_q.initial_time;
      qok_q[free_idx_q] <= item_q.quote_enabled;
      ook_q[free_idx_q] <= item_q.order_enabled;
    end
    if (wr_hb) begin
      cnt_q[slot_q] <= hb_reload_q;
    end
    if (do_tick) begin
      for (int i = 0; i < Depth; i++) begin
        if (valid_q[i] && cnt_q[i] != '0) begin
          cnt_q[i] <= cnt_q[i] - ste_pkg::TimeW'(1);
        end
      end
    end
  end

`ifndef SYNTH
  a_gone_not_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gone_q & valid_q) == '0)
    else $error("removed entry still marked valid");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) <= Depth)
    else $error("live count exceeds table depth");

  a_expired_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.expired |-> out_q.ok && !out_q.last)
    else $error("expiry result malformed");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_EXEC)
    else $error("popped item not executed");
`endif

endmodule

// ----- rtl/session_table_with_aging.sv -----
// Top level of the session table with aging: front queue plus back executor.
// Depends on ste_pkg, ste_front and ste_back.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  ste_pkg::in_item_t
//   out      output     out_valid_o/out_stall_i ste_pkg::out_item_t
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// In the back end a non-tick command is latched and compared, then executed.
// A tick is latched, classified and marks expired entries, then k+1 rounds of a full
// table scan plus one emit each follow for k expired sessions.
// Reset clears the table valid bits and loads register defaults; no clearing pass.
// Output stall holds the result register; the two-entry input queue absorbs items.
module session_table_with_aging #(
  parameter int unsigned TableDepth = ste_pkg::DepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ste_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ste_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [ste_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ste_pkg::CfgDataW-1:0] cfg_wdata_i
);

  ste_pkg::head_t head;
  logic           pop;

  ste_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  ste_back #(
    .Depth (TableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
